// ===== design/cqcf_pkg.sv =====
package cqcf_pkg;

    // Sizes
    localparam int QUEUE_DEPTH_DEF = 32;
    localparam int MAX_RESULTS     = 32;
    localparam int CHAR_W          = 8;
    localparam int CNT_W           = 4;
    localparam int NUM_CLASSES     = 4;
    localparam logic [CNT_W-1:0] CLASS_LIMIT_RST = 4'd5;

    // Action codes
    localparam logic [1:0] ACT_PUSH = 2'd0;
    localparam logic [1:0] ACT_POP  = 2'd1;
    localparam logic [1:0] ACT_DUMP = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_REFUSED = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;

    // Character classes
    localparam logic [1:0] CLS_DIGIT  = 2'd0;
    localparam logic [1:0] CLS_LOWER  = 2'd1;
    localparam logic [1:0] CLS_UPPER  = 2'd2;
    localparam logic [1:0] CLS_SYMBOL = 2'd3;

    localparam logic [CHAR_W-1:0] CH_0     = "0";
    localparam logic [CHAR_W-1:0] CH_9     = "9";
    localparam logic [CHAR_W-1:0] CH_LC_A  = "a";
    localparam logic [CHAR_W-1:0] CH_LC_Z  = "z";
    localparam logic [CHAR_W-1:0] CH_UC_A  = "A";
    localparam logic [CHAR_W-1:0] CH_UC_Z  = "Z";

    // Controller to datapath commands
    typedef struct packed {
        logic accept;     // input transaction taken this cycle
        logic rd_load;    // memory read data is ready, build result from it
        logic dump_next;  // result taken during a dump, fetch the next byte
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic act_push;   // pending input is a push
        logic act_read;   // pending input is a pop or a dump
        logic occ_zero;   // queue is empty
        logic more;       // dump has further bytes after the held result
    } t_dp_sts;

    // Classify one byte
    function automatic logic [1:0] class_of(input logic [CHAR_W-1:0] b);
        logic [1:0] c;
        if (b >= CH_0 && b <= CH_9) begin
            c = CLS_DIGIT;
        end else if (b >= CH_LC_A && b <= CH_LC_Z) begin
            c = CLS_LOWER;
        end else if (b >= CH_UC_A && b <= CH_UC_Z) begin
            c = CLS_UPPER;
        end else begin
            c = CLS_SYMBOL;
        end
        return c;
    endfunction

endpackage

// ===== design/cqcf_in_if.sv =====
interface cqcf_in_if import cqcf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        action;
    logic [CHAR_W-1:0] char_in;

    modport source (output valid, output action, output char_in, input ready);
    modport sink   (input valid, input action, input char_in, output ready);
endinterface

// ===== design/cqcf_out_if.sv =====
interface cqcf_out_if import cqcf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [CHAR_W-1:0] char_out;
    logic              char_valid;
    logic              last_of_run;
    logic [CNT_W-1:0]  digit_count;
    logic [CNT_W-1:0]  lower_count;
    logic [CNT_W-1:0]  upper_count;
    logic [CNT_W-1:0]  symbol_count;

    modport source (output valid, output status, output char_out, output char_valid,
                    output last_of_run, output digit_count, output lower_count,
                    output upper_count, output symbol_count, input ready);
    modport sink   (input valid, input status, input char_out, input char_valid,
                    input last_of_run, input digit_count, input lower_count,
                    input upper_count, input symbol_count, output ready);
endinterface

// ===== design/cqcf_ctrl.sv =====
module cqcf_ctrl import cqcf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_HOLD
    } t_state;

    t_state r_state;
    logic   r_in_ready;
    logic   r_out_valid;

    // Commands to the datapath
    always_comb begin
        o_cmd.accept    = r_in_ready & i_in_valid;
        o_cmd.rd_load   = (r_state == S_READ);
        o_cmd.dump_next = (r_state == S_HOLD) & i_out_ready & i_sts.more;
    end

    // State and registered handshake outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        if (i_sts.act_push || (i_sts.act_read && i_sts.occ_zero)) begin
                            r_state     <= S_HOLD;
                            r_in_ready  <= 1'b0;
                            r_out_valid <= 1'b1;
                        end else if (i_sts.act_read) begin
                            r_state    <= S_READ;
                            r_in_ready <= 1'b0;
                        end
                    end
                end
                S_READ: begin
                    r_state     <= S_HOLD;
                    r_out_valid <= 1'b1;
                end
                S_HOLD: begin
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                        if (i_sts.more) begin
                            r_state <= S_READ;
                        end else begin
                            r_state    <= S_IDLE;
                            r_in_ready <= 1'b1;
                        end
                    end
                end
                default: begin
                    r_state     <= S_IDLE;
                    r_in_ready  <= 1'b1;
                    r_out_valid <= 1'b0;
                end
            endcase
        end
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

endmodule

// ===== design/cqcf_dp.sv =====
module cqcf_dp import cqcf_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts,
    input  logic [1:0]        i_action,
    input  logic [CHAR_W-1:0] i_char_in,
    input  logic              i_cfg_wr_en,
    input  logic [CNT_W-1:0]  i_cfg_wr_data,
    output logic [1:0]        o_status,
    output logic [CHAR_W-1:0] o_char_out,
    output logic              o_char_valid,
    output logic              o_last_of_run,
    output logic [CNT_W-1:0]  o_digit_count,
    output logic [CNT_W-1:0]  o_lower_count,
    output logic [CNT_W-1:0]  o_upper_count,
    output logic [CNT_W-1:0]  o_symbol_count
);

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int OCC_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int LEFT_W = $clog2(MAX_RESULTS + 1);

    logic [CHAR_W-1:0] mem [QUEUE_DEPTH];

    logic [PTR_W-1:0]  r_head;
    logic [PTR_W-1:0]  r_tail;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [OCC_W-1:0]  r_occ;
    logic [CNT_W-1:0]  r_cnt [NUM_CLASSES];
    logic [CNT_W-1:0]  n_cnt [NUM_CLASSES];
    logic [CNT_W-1:0]  r_limit;
    logic [LEFT_W-1:0] r_left;
    logic              r_is_dump;
    logic              r_more;
    logic [CHAR_W-1:0] r_rd_data;

    logic [1:0]        r_res_status;
    logic [CHAR_W-1:0] r_res_char;
    logic              r_res_valid;
    logic              r_res_last;

    logic [1:0]        push_cls;
    logic [1:0]        pop_cls;
    logic              occ_full;
    logic              push_refused;
    logic              push_do;
    logic              pop_do;
    logic              rd_start;
    logic              rd_en;
    logic [PTR_W-1:0]  rd_addr;
    logic [PTR_W-1:0]  rd_ptr_inc;
    logic [PTR_W-1:0]  head_inc;
    logic [PTR_W-1:0]  tail_inc;
    logic [LEFT_W-1:0] dump_len;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Decode and queue conditions
    always_comb begin
        push_cls     = class_of(i_char_in);
        pop_cls      = class_of(r_rd_data);
        occ_full     = (r_occ == OCC_W'(QUEUE_DEPTH));
        push_refused = occ_full || (r_cnt[push_cls] >= r_limit);
        push_do      = i_cmd.accept && (i_action == ACT_PUSH) && !push_refused;
        pop_do       = i_cmd.rd_load && !r_is_dump;
        rd_start     = i_cmd.accept && (r_occ != '0) &&
                       ((i_action == ACT_POP) || (i_action == ACT_DUMP));
        rd_en        = rd_start || i_cmd.dump_next;
        rd_ptr_inc   = ptr_inc(r_rd_ptr);
        head_inc     = ptr_inc(r_head);
        tail_inc     = ptr_inc(r_tail);
        rd_addr      = i_cmd.dump_next ? rd_ptr_inc : r_head;
        if (int'(r_occ) > MAX_RESULTS) begin
            dump_len = LEFT_W'(MAX_RESULTS);
        end else begin
            dump_len = LEFT_W'(r_occ);
        end
    end

    // Class counter next values
    always_comb begin
        for (int k = 0; k < NUM_CLASSES; k++) begin
            n_cnt[k] = r_cnt[k];
            if (push_do && (push_cls == 2'(k))) begin
                n_cnt[k] = r_cnt[k] + 1'b1;
            end else if (pop_do && (pop_cls == 2'(k)) && (r_cnt[k] != '0)) begin
                n_cnt[k] = r_cnt[k] - 1'b1;
            end
        end
    end

    // Byte store, registered read
    always_ff @(posedge i_clk) begin
        if (push_do) begin
            mem[r_tail] <= i_char_in;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // Control registers: pointers, counts, limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_occ   <= '0;
            r_limit <= CLASS_LIMIT_RST;
            r_more  <= 1'b0;
            for (int k = 0; k < NUM_CLASSES; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
            for (int k = 0; k < NUM_CLASSES; k++) begin
                r_cnt[k] <= n_cnt[k];
            end
            if (push_do) begin
                r_tail <= tail_inc;
                r_occ  <= r_occ + 1'b1;
            end
            if (pop_do) begin
                r_head <= head_inc;
                r_occ  <= r_occ - 1'b1;
            end
            if (i_cmd.accept) begin
                r_more <= 1'b0;
            end else if (i_cmd.rd_load) begin
                r_more <= r_is_dump && (r_left != LEFT_W'(1));
            end
        end
    end

    // Read walk and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            case (i_action)
                ACT_PUSH: begin
                    r_res_status <= push_refused ? ST_REFUSED : ST_OK;
                    r_res_char   <= '0;
                    r_res_valid  <= 1'b0;
                    r_res_last   <= 1'b1;
                end
                ACT_POP, ACT_DUMP: begin
                    r_res_status <= ST_EMPTY;
                    r_res_char   <= '0;
                    r_res_valid  <= 1'b0;
                    r_res_last   <= 1'b1;
                    r_rd_ptr     <= r_head;
                    r_left       <= dump_len;
                    r_is_dump    <= (i_action == ACT_DUMP);
                end
                default: ;
            endcase
        end
        if (i_cmd.rd_load) begin
            r_res_status <= ST_OK;
            r_res_char   <= r_rd_data;
            r_res_valid  <= 1'b1;
            r_res_last   <= !r_is_dump || (r_left == LEFT_W'(1));
        end
        if (i_cmd.dump_next) begin
            r_rd_ptr <= rd_ptr_inc;
            r_left   <= r_left - 1'b1;
        end
    end

    // Status to controller
    always_comb begin
        o_sts.act_push = (i_action == ACT_PUSH);
        o_sts.act_read = (i_action == ACT_POP) || (i_action == ACT_DUMP);
        o_sts.occ_zero = (r_occ == '0);
        o_sts.more     = r_more;
    end

    assign o_status       = r_res_status;
    assign o_char_out     = r_res_char;
    assign o_char_valid   = r_res_valid;
    assign o_last_of_run  = r_res_last;
    assign o_digit_count  = r_cnt[CLS_DIGIT];
    assign o_lower_count  = r_cnt[CLS_LOWER];
    assign o_upper_count  = r_cnt[CLS_UPPER];
    assign o_symbol_count = r_cnt[CLS_SYMBOL];

endmodule

// ===== design/class_quota_char_fifo_core.sv =====
// Push, refused push and pop/dump on an empty queue: result valid in the cycle after acceptance.
// Pop and each dump byte: the store read is registered, then the result register is loaded from it.
// A dump returns n bytes, n at most 32;
// one item at a time, the next is taken the cycle after the final result is taken.
// Reset (synchronous, active low): empty queue, zero class counts, class limit 5;
// the byte store is not cleared and needs no clearing pass.
module class_quota_char_fifo_core import cqcf_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [CNT_W-1:0] i_cfg_wr_data,
    cqcf_in_if.sink          i_in,
    cqcf_out_if.source       o_out
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Transaction sequencing
    cqcf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Queue storage, class counters and result register
    cqcf_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_action       (i_in.action),
        .i_char_in      (i_in.char_in),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .o_status       (o_out.status),
        .o_char_out     (o_out.char_out),
        .o_char_valid   (o_out.char_valid),
        .o_last_of_run  (o_out.last_of_run),
        .o_digit_count  (o_out.digit_count),
        .o_lower_count  (o_out.lower_count),
        .o_upper_count  (o_out.upper_count),
        .o_symbol_count (o_out.symbol_count)
    );

endmodule
